// ===== rtl/tsb_pkg.sv =====
package tsb_pkg;

    localparam int TEXTURE_SLOTS   = 32;
    localparam int SLOT_W          = 5;
    localparam int SLOTS_USED_W    = 6;
    localparam int BATCH_QUADS_MAX = 1024;
    localparam int QUADS_W         = 11;
    localparam int QIDX_W          = 10;
    localparam int TEX_ID_W        = 16;
    localparam int TEX_CNT_W       = 6;
    localparam int OP_W            = 2;
    localparam int APB_DATA_W      = 32;
    localparam int APB_ADDR_W      = 3;

    localparam logic [QUADS_W-1:0] MAX_QUADS_RESET = 11'd1000;
    localparam logic [QUADS_W-1:0] QUAD_LIMIT      = QUADS_W'(BATCH_QUADS_MAX);

    typedef logic [OP_W-1:0] opcode_t;

    localparam opcode_t OP_DRAW  = 2'd0;
    localparam opcode_t OP_END   = 2'd1;
    localparam opcode_t OP_BEGIN = 2'd2;

    // register index, taken from paddr[2]
    localparam logic REG_MAX_QUADS = 1'b0;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic commit;
    } tsb_cmd_t;

    typedef struct packed {
        logic out_free;
    } tsb_status_t;

endpackage

// ===== rtl/tsb_ctrl.sv =====
module tsb_ctrl
    import tsb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  tsb_status_t status,
    output tsb_cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_COMMIT
    } state_t;

    state_t state_reg;
    logic   in_ready_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready_reg)
                    begin
                        state_reg    <= S_LOOK;
                        in_ready_reg <= 1'b0;
                    end
                end
                S_LOOK:
                begin
                    state_reg <= S_COMMIT;
                end
                S_COMMIT:
                begin
                    // wait for the output register to free up
                    if (status.out_free)
                    begin
                        state_reg    <= S_IDLE;
                        in_ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg    <= S_IDLE;
                    in_ready_reg <= 1'b1;
                end
            endcase
        end
    end

    assign in_ready = in_ready_reg;

    always_comb
    begin
        cmd.capture = in_valid && in_ready_reg;
        cmd.lookup  = (state_reg == S_LOOK);
        cmd.commit  = (state_reg == S_COMMIT) && status.out_free;
    end

endmodule

// ===== rtl/tsb_datapath.sv =====
module tsb_datapath
    import tsb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tsb_cmd_t             cmd,
    output tsb_status_t          status,
    input  logic [OP_W-1:0]      opcode,
    input  logic [TEX_ID_W-1:0]  texture_id,
    input  logic                 cfg_we,
    input  logic [QUADS_W-1:0]   cfg_wdata,
    output logic [QUADS_W-1:0]   max_quads,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [SLOT_W-1:0]    slot,
    output logic [QIDX_W-1:0]    quad_index,
    output logic                 flushed,
    output logic [QUADS_W-1:0]   flush_quads,
    output logic [TEX_CNT_W-1:0] flush_textures
);

    opcode_t                 op_reg;
    logic [TEX_ID_W-1:0]     id_reg;
    logic [TEX_ID_W-1:0]     slot_table_reg [1:TEXTURE_SLOTS-1];
    logic [SLOTS_USED_W-1:0] slots_used_reg, slots_used_next;
    logic [QUADS_W-1:0]      batch_quads_reg, batch_quads_next;
    logic [QUADS_W-1:0]      max_quads_reg;
    logic                    hit_reg;
    logic [SLOT_W-1:0]       hit_slot_reg;
    logic                    full_reg;

    logic                    out_valid_reg;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic [QIDX_W-1:0]       quad_index_reg, quad_index_next;
    logic                    flushed_reg, flushed_next;
    logic [QUADS_W-1:0]      flush_quads_reg, flush_quads_next;
    logic [TEX_CNT_W-1:0]    flush_textures_reg, flush_textures_next;

    logic [TEXTURE_SLOTS-1:0] match;
    logic [SLOT_W-1:0]        hit_slot;
    logic [QUADS_W-1:0]       limit;
    logic                     overflow;
    logic                     table_we;

    // slot 0 always holds the default texture
    assign match[0] = (id_reg == '0);

    for (genvar s = 1; s < TEXTURE_SLOTS; s++)
    begin : g_match
        assign match[s] = (slot_table_reg[s] == id_reg) &&
                          (SLOTS_USED_W'(s) < slots_used_reg);
    end

    always_comb
    begin
        hit_slot = '0;
        for (int s = TEXTURE_SLOTS - 1; s >= 0; s--)
        begin
            if (match[s])
            begin
                hit_slot = SLOT_W'(s);
            end
        end
    end

    assign limit = (max_quads_reg > QUAD_LIMIT) ? QUAD_LIMIT : max_quads_reg;

    always_comb
    begin
        slots_used_next     = slots_used_reg;
        batch_quads_next    = batch_quads_reg;
        slot_next           = '0;
        quad_index_next     = '0;
        flushed_next        = 1'b0;
        table_we            = 1'b0;
        overflow            = !hit_reg &&
                              (slots_used_reg == SLOTS_USED_W'(TEXTURE_SLOTS));
        case (op_reg)
            OP_DRAW:
            begin
                // a full-batch flush and an overflow flush report the same
                // counts; either one restarts the batch with the drawn quad at index 0
                flushed_next = (batch_quads_reg != '0) && (full_reg || overflow);
                if (hit_reg)
                begin
                    slot_next = hit_slot_reg;
                end
                else
                begin
                    slot_next       = overflow ? SLOT_W'(1) : slots_used_reg[SLOT_W-1:0];
                    slots_used_next = SLOTS_USED_W'({1'b0, slot_next} + 1'b1);
                    table_we        = 1'b1;
                end
                quad_index_next  = flushed_next ? '0 : batch_quads_reg[QIDX_W-1:0];
                batch_quads_next = QUADS_W'({1'b0, quad_index_next} + 1'b1);
            end
            OP_END:
            begin
                flushed_next     = (batch_quads_reg != '0);
                batch_quads_next = '0;
            end
            OP_BEGIN:
            begin
                batch_quads_next = '0;
                slots_used_next  = SLOTS_USED_W'(1);
            end
            default:
            begin
            end
        endcase
        flush_quads_next    = flushed_next ? batch_quads_reg : '0;
        flush_textures_next = flushed_next ? TEX_CNT_W'(slots_used_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_used_reg  <= SLOTS_USED_W'(1);
            batch_quads_reg <= '0;
            max_quads_reg   <= MAX_QUADS_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_quads_reg <= cfg_wdata;
            end
            if (cmd.commit)
            begin
                slots_used_reg  <= slots_used_next;
                batch_quads_reg <= batch_quads_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= opcode;
            id_reg <= texture_id;
        end
        if (cmd.lookup)
        begin
            hit_reg      <= |match;
            hit_slot_reg <= hit_slot;
            full_reg     <= (batch_quads_reg >= limit);
        end
        if (cmd.commit)
        begin
            slot_reg           <= slot_next;
            quad_index_reg     <= quad_index_next;
            flushed_reg        <= flushed_next;
            flush_quads_reg    <= flush_quads_next;
            flush_textures_reg <= flush_textures_next;
        end
        if (cmd.commit && table_we)
        begin
            slot_table_reg[slot_next] <= id_reg;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign max_quads       = max_quads_reg;
    assign out_valid       = out_valid_reg;
    assign slot            = slot_reg;
    assign quad_index      = quad_index_reg;
    assign flushed         = flushed_reg;
    assign flush_quads     = flush_quads_reg;
    assign flush_textures  = flush_textures_reg;

`ifndef SYNTH
    a_slots_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        (slots_used_reg != '0) && (slots_used_reg <= SLOTS_USED_W'(TEXTURE_SLOTS)))
        else $error("slots_used out of range");

    a_draw_grows_batch: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && (op_reg == OP_DRAW)) |=> (batch_quads_reg != '0))
        else $error("draw left an empty batch");

    a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && flushed_reg) |-> (flush_quads_reg != '0))
        else $error("flush beat reports an empty batch");

    a_noflush_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !flushed_reg) |->
        ((flush_quads_reg == '0) && (flush_textures_reg == '0)))
        else $error("flush counts set without a flush");
`endif

endmodule

// ===== rtl/texture_slot_batch_binder.sv =====
// Texture slot batch binder.
// Input channel (in_valid/in_ready) carries one beat per command: opcode
// (draw quad, end scene, begin scene) and texture_id. Every input beat yields
// exactly one output beat (out_valid/out_ready) with the assigned slot, the
// quad index and any flush report (flushed, flush_quads, flush_textures).
// Each beat passes through accept, slot lookup (all 32 slot entries compared
// in parallel, result registered), then commit of state and the output
// register. The next beat is accepted only once the previous one has
// committed. The result sits in an output register, so a new beat is accepted
// and looked up while the previous result still waits; a stalled receiver
// holds the commit step until the output register is taken.
// max_quads is written through the APB port at byte address 0; pready is
// always high and reads return the register.
// Reset (rst_n low, asynchronous) empties the batch, leaves only the default
// texture in slot 0, sets max_quads to 1000 and drops out_valid.
module texture_slot_batch_binder
    import tsb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [OP_W-1:0]        opcode,
    input  logic [TEX_ID_W-1:0]    texture_id,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SLOT_W-1:0]      slot,
    output logic [QIDX_W-1:0]      quad_index,
    output logic                   flushed,
    output logic [QUADS_W-1:0]     flush_quads,
    output logic [TEX_CNT_W-1:0]   flush_textures
);

    tsb_cmd_t           cmd;
    tsb_status_t        status;
    logic               cfg_we;
    logic               reg_idx;
    logic [QUADS_W-1:0] max_quads;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1];
    assign cfg_we  = psel && penable && pwrite && (reg_idx == REG_MAX_QUADS);
    assign prdata  = (reg_idx == REG_MAX_QUADS) ? APB_DATA_W'(max_quads) : '0;

    tsb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tsb_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .opcode         (opcode),
        .texture_id     (texture_id),
        .cfg_we         (cfg_we),
        .cfg_wdata      (pwdata[QUADS_W-1:0]),
        .max_quads      (max_quads),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .slot           (slot),
        .quad_index     (quad_index),
        .flushed        (flushed),
        .flush_quads    (flush_quads),
        .flush_textures (flush_textures)
    );

endmodule
